// ----- rtl/core/avt_pkg.sv -----
// ----------------------------------------------------------------------------
// avt_pkg
// Shared codes and types of the affine vertex transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package avt_pkg;

  localparam int CMD_WIDTH       = 2;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int LANES           = 3;

  // per-item command, carried in tuser
  localparam logic [CMD_WIDTH-1:0] CMD_AFFINE     = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_LINEAR     = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_TRANSPOSED = 2'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_SUBTRACT   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_X   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Z = 3'd5;

  // stage load enables handed from the pipeline control to the lanes
  typedef struct packed {
    logic ld_mul;   // product stage
    logic ld_sum;   // rounded sum stage
    logic ld_out;   // translate / saturate stage
  } avt_pipe_ctrl_t;

endpackage

// ----- rtl/core/avt_cfg.sv -----
// ----------------------------------------------------------------------------
// avt_cfg
// Configuration registers: 3x3 coefficient matrix and translation vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avt_cfg #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16,
  parameter int DATA_WIDTH  = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [avt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]                 cfg_data,
  output logic signed [COEF_WIDTH-1:0]          coef [avt_pkg::LANES][avt_pkg::LANES],
  output logic signed [COORD_WIDTH-1:0]         shift [avt_pkg::LANES]
);
  import avt_pkg::*;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          coef[i][j] <= (i == j) ? COEF_ONE : '0;
        end
        shift[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
          for (int j = 0; j < LANES; j++) begin
            coef[cfg_index[1:0]][j] <= cfg_data[j*COEF_WIDTH +: COEF_WIDTH];
          end
        end
        REG_SHIFT_X: shift[0] <= cfg_data[COORD_WIDTH-1:0];
        REG_SHIFT_Y: shift[1] <= cfg_data[COORD_WIDTH-1:0];
        REG_SHIFT_Z: shift[2] <= cfg_data[COORD_WIDTH-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

endmodule

// ----- rtl/core/avt_lane.sv -----
// ----------------------------------------------------------------------------
// avt_lane
// One output coordinate: three products, rounded sum, translation, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avt_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                          clk,
  input  avt_pkg::avt_pipe_ctrl_t       ctrl,
  input  logic signed [COORD_WIDTH-1:0] vec    [avt_pkg::LANES],
  input  logic signed [COEF_WIDTH-1:0]  coef   [avt_pkg::LANES],
  input  logic signed [COORD_WIDTH:0]   addend,
  output logic signed [COORD_WIDTH-1:0] result,
  output logic                          ovf
);
  import avt_pkg::*;

  localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC   = COEF_WIDTH - 2;
  localparam int RND_W  = SUM_W - FRAC;
  localparam int ADD_W  = RND_W + 1;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC - 1);
  localparam logic [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PROD_W-1:0]      prod [LANES];
  logic signed [COORD_WIDTH:0]   addend_mul;
  logic signed [RND_W-1:0]       rnd;
  logic signed [COORD_WIDTH:0]   addend_sum;
  logic signed [SUM_W-1:0]       sum;
  logic signed [ADD_W-1:0]       total;
  logic                          fits;

  // stage: products
  always_ff @(posedge clk) begin
    if (ctrl.ld_mul) begin
      for (int j = 0; j < LANES; j++) begin
        prod[j] <= PROD_W'(vec[j]) * PROD_W'(coef[j]);
      end
      addend_mul <= addend;
    end
  end

  // stage: sum, round half up, drop the coefficient fraction
  assign sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + HALF;

  always_ff @(posedge clk) begin
    if (ctrl.ld_sum) begin
      rnd        <= sum[SUM_W-1:FRAC];
      addend_sum <= addend_mul;
    end
  end

  // stage: translation and clamp
  assign total = ADD_W'(rnd) + ADD_W'(addend_sum);
  assign fits  = (&total[ADD_W-1:COORD_WIDTH-1]) || !(|total[ADD_W-1:COORD_WIDTH-1]);

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      ovf <= !fits;
      if (fits) begin
        result <= total[COORD_WIDTH-1:0];
      end else begin
        result <= total[ADD_W-1] ? NEG_MIN : POS_MAX;
      end
    end
  end

endmodule

// ----- rtl/core/affine_vertex_transform.sv -----
// ----------------------------------------------------------------------------
// affine_vertex_transform
// Transforms one fixed-point 3D point per transaction by a 3x3 matrix and a
// translation. Accepts items and returns one result per item. The four
// register stages are operand select, multiply (nine COORDxCOEF products),
// rounded sum and translate/saturate; valid bits travel with the data and an
// output stall holds each occupied stage with no empty stage after it, so
// throughput stays at one item per cycle as long as the consumer takes
// results. The per-item command picks affine, linear only, transposed linear
// or subtract translation. The user must write configuration through cfg_*
// only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_vertex_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst,
  // tdata: in_x, in_y, in_z (COORD_WIDTH each), zero pad to bytes
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  // tuser: command
  input  logic [avt_pkg::CMD_WIDTH-1:0]               s_axis_tuser,
  // tdata: out_x, out_y, out_z (COORD_WIDTH each), zero pad to bytes
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // tuser: overflow
  output logic                                        m_axis_tuser,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [avt_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
  input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0] cfg_data
);
  import avt_pkg::*;

  localparam int DATA_W   = ((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH);
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 2);

  logic signed [COEF_WIDTH-1:0]  cfg_coef  [LANES][LANES];
  logic signed [COORD_WIDTH-1:0] cfg_shift [LANES];

  logic signed [COORD_WIDTH-1:0] vec_in    [LANES];
  logic signed [COEF_WIDTH-1:0]  coef_next [LANES][LANES];
  logic signed [COORD_WIDTH:0]   add_next  [LANES];

  // operand stage registers
  logic signed [COORD_WIDTH-1:0] vec       [LANES];
  logic signed [COEF_WIDTH-1:0]  lane_coef [LANES][LANES];
  logic signed [COORD_WIDTH:0]   lane_add  [LANES];

  logic signed [COORD_WIDTH-1:0] lane_res  [LANES];
  logic [LANES-1:0]              lane_ovf;

  logic valid_op, valid_mul, valid_sum, valid_out;
  logic rdy_op, rdy_mul, rdy_sum, rdy_out;
  avt_pipe_ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  avt_cfg #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .DATA_WIDTH  (DATA_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (cfg_coef),
    .shift     (cfg_shift)
  );

  // backpressure chain; each stage advances when the one after can take it
  assign rdy_out = !valid_out || m_axis_tready;
  assign rdy_sum = !valid_sum || rdy_out;
  assign rdy_mul = !valid_mul || rdy_sum;
  assign rdy_op  = !valid_op  || rdy_mul;

  assign s_axis_tready = rdy_op;
  assign ctrl.ld_mul   = rdy_mul;
  assign ctrl.ld_sum   = rdy_sum;
  assign ctrl.ld_out   = rdy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_op  <= 1'b0;
      valid_mul <= 1'b0;
      valid_sum <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      if (rdy_op)  valid_op  <= s_axis_tvalid;
      if (rdy_mul) valid_mul <= valid_op;
      if (rdy_sum) valid_sum <= valid_mul;
      if (rdy_out) valid_out <= valid_sum;
    end
  end

  // operand select: subtract runs as identity matrix with negated shift
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      vec_in[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      for (int j = 0; j < LANES; j++) begin
        unique case (s_axis_tuser)
          CMD_AFFINE, CMD_LINEAR: coef_next[i][j] = cfg_coef[i][j];
          CMD_TRANSPOSED:         coef_next[i][j] = cfg_coef[j][i];
          CMD_SUBTRACT:           coef_next[i][j] = (i == j) ? COEF_ONE : '0;
          default:                coef_next[i][j] = cfg_coef[i][j];
        endcase
      end
      unique case (s_axis_tuser)
        CMD_AFFINE:                 add_next[i] = (COORD_WIDTH+1)'(cfg_shift[i]);
        CMD_SUBTRACT:               add_next[i] = -((COORD_WIDTH+1)'(cfg_shift[i]));
        CMD_LINEAR, CMD_TRANSPOSED: add_next[i] = '0;
        default:                    add_next[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_op) begin
      vec       <= vec_in;
      lane_coef <= coef_next;
      lane_add  <= add_next;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    avt_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .vec    (vec),
      .coef   (lane_coef[i]),
      .addend (lane_add[i]),
      .result (lane_res[i]),
      .ovf    (lane_ovf[i])
    );
  end

  assign m_axis_tvalid = valid_out;
  assign m_axis_tuser  = |lane_ovf;

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < LANES; i++) begin
      m_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH] = lane_res[i];
    end
  end

endmodule

// ----- rtl/core/avt_checker.sv -----
// ----------------------------------------------------------------------------
// avt_checker
// Port-level checks of the affine vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avt_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  input logic                                 m_axis_tuser
);

  localparam logic [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic s_xfer;
  logic [COORD_WIDTH-1:0] ox, oy, oz;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign ox = m_axis_tdata[COORD_WIDTH-1:0];
  assign oy = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign oz = m_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // nothing comes out of a freshly reset pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // with a free-running consumer and no reset, an accepted transaction reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(s_xfer, 4) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
      && $past(m_axis_tready, 3) && !$past(rst, 1) && !$past(rst, 2)
      && !$past(rst, 3) && !$past(rst, 4) |-> m_axis_tvalid)
    else $error("result missing at expected latency");

  // overflow only with a coordinate sitting on a bound
  a_ovf_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      ox == POS_MAX || ox == NEG_MIN || oy == POS_MAX || oy == NEG_MIN
      || oz == POS_MAX || oz == NEG_MIN)
    else $error("overflow flagged without a clamped coordinate");

endmodule

bind affine_vertex_transform avt_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_avt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
